/* rtl/akcl_pkg.sv */
// Shared types and constants of the alarm keypad code lock.
`default_nettype none

package akcl_pkg;

  // Item kinds carried in the func field.
  localparam logic FuncKey  = 1'b0;
  localparam logic FuncTick = 1'b1;

  // Key codes with a meaning of their own.
  localparam logic [7:0] KeyNone = 8'h00;
  localparam logic [7:0] KeyHash = 8'h23;

  // Failure counter saturation point.
  localparam logic [7:0] WrongCountMax = 8'hFF;

  // Configuration reset values.
  localparam logic [31:0]        CodeValueReset     = 32'h3230_3035;  // "2005"
  localparam logic signed [11:0] TempLimitReset     = 12'sd300;
  localparam logic [7:0]         WrongTryLimitReset = 8'd3;
  localparam logic [15:0]        RefreshTicksReset  = 16'd100;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgCodeValue     = 2'd0,
    CfgTempLimit     = 2'd1,
    CfgWrongTryLimit = 2'd2,
    CfgRefreshTicks  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                func;
    logic [7:0]          key_code;
    logic signed [11:0]  temperature;
    logic                gas_detected;
  } item_t;

  typedef struct packed {
    logic alarm_active;
    logic incorrect_code;
    logic system_blocked;
    logic code_complete;
    logic temp_alarm;
    logic gas_alarm;
    logic code_accepted;
  } result_t;

  typedef struct packed {
    logic [31:0]         code_value;
    logic signed [11:0]  temp_limit;
    logic [7:0]          wrong_try_limit;
    logic [15:0]         refresh_ticks;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/akcl_if.sv */
// Valid/ready channel interfaces of the alarm keypad code lock.
`default_nettype none

interface akcl_item_if;
  logic                valid;
  logic                ready;
  akcl_pkg::item_t     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface akcl_result_if;
  logic                valid;
  logic                ready;
  akcl_pkg::result_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface akcl_cfg_if;
  logic                valid;
  logic                ready;
  akcl_pkg::cfg_idx_e  index;
  logic [31:0]         data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/akcl_cfg_regs.sv */
// Configuration register bank of the alarm keypad code lock.
`default_nettype none

module akcl_cfg_regs (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  akcl_cfg_if.sink        cfg_if,
  output akcl_pkg::cfg_t  cfg_o
);

  akcl_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        akcl_pkg::CfgCodeValue:     cfg_d.code_value      = cfg_if.data;
        akcl_pkg::CfgTempLimit:     cfg_d.temp_limit      = signed'(cfg_if.data[11:0]);
        akcl_pkg::CfgWrongTryLimit: cfg_d.wrong_try_limit = cfg_if.data[7:0];
        akcl_pkg::CfgRefreshTicks:  cfg_d.refresh_ticks   = cfg_if.data[15:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_value      <= akcl_pkg::CodeValueReset;
      cfg_q.temp_limit      <= akcl_pkg::TempLimitReset;
      cfg_q.wrong_try_limit <= akcl_pkg::WrongTryLimitReset;
      cfg_q.refresh_ticks   <= akcl_pkg::RefreshTicksReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/akcl_core.sv */
// Lock and sensor state with the per-item update logic.
`default_nettype none

module akcl_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,   // item in the input register is processed
  input  wire akcl_pkg::item_t  item_i,
  input  wire akcl_pkg::cfg_t   cfg_i,
  output akcl_pkg::result_t     result_o  // flags after this item's update
);

  // Only the first three keys are stored; the fourth is compared on arrival.
  logic [7:0]  keys_q [3];
  logic [1:0]  key_count_q, key_count_d;
  logic [7:0]  wrong_count_q, wrong_count_d;
  logic        hash_count_q, hash_count_d;
  logic        incorrect_q, incorrect_d;
  logic        blocked_q, blocked_d;
  logic        complete_q, complete_d;
  logic        alarm_q, alarm_d;
  logic        temp_q, temp_d;
  logic        gas_q, gas_d;
  logic [15:0] tick_count_q, tick_count_d;
  logic        accepted;
  logic        key_store;
  logic        code_match;

  assign code_match = (keys_q[0] == cfg_i.code_value[31:24])
                   && (keys_q[1] == cfg_i.code_value[23:16])
                   && (keys_q[2] == cfg_i.code_value[15:8])
                   && (item_i.key_code == cfg_i.code_value[7:0]);

  always_comb begin
    logic [7:0] wrong_inc;
    key_count_d   = key_count_q;
    wrong_count_d = wrong_count_q;
    hash_count_d  = hash_count_q;
    incorrect_d   = incorrect_q;
    blocked_d     = blocked_q;
    complete_d    = complete_q;
    alarm_d       = alarm_q;
    temp_d        = temp_q;
    gas_d         = gas_q;
    tick_count_d  = tick_count_q;
    accepted      = 1'b0;
    key_store     = 1'b0;
    wrong_inc     = (wrong_count_q == akcl_pkg::WrongCountMax) ? wrong_count_q
                                                               : wrong_count_q + 8'd1;
    if (item_i.func == akcl_pkg::FuncTick) begin
      if (tick_count_q >= cfg_i.refresh_ticks) begin
        tick_count_d = '0;
        if (!alarm_q) begin
          temp_d  = (item_i.temperature >= cfg_i.temp_limit);
          gas_d   = item_i.gas_detected;
          alarm_d = (item_i.temperature >= cfg_i.temp_limit) || item_i.gas_detected;
        end
      end else begin
        tick_count_d = tick_count_q + 16'd1;
      end
    end else if (item_i.key_code != akcl_pkg::KeyNone && alarm_q && !blocked_q) begin
      if (!incorrect_q) begin
        key_count_d = key_count_q + 2'd1;
        if (key_count_q == 2'd3) begin
          complete_d = 1'b1;
          if (code_match) begin
            alarm_d  = 1'b0;
            accepted = 1'b1;
          end else begin
            incorrect_d   = 1'b1;
            wrong_count_d = wrong_inc;
            if (wrong_inc >= cfg_i.wrong_try_limit) begin
              blocked_d = 1'b1;
            end
          end
        end else begin
          key_store = 1'b1;
        end
      end else if (item_i.key_code == akcl_pkg::KeyHash) begin
        if (!hash_count_q) begin
          hash_count_d = 1'b1;
        end else begin
          hash_count_d = 1'b0;
          key_count_d  = '0;
          complete_d   = 1'b0;
          incorrect_d  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q   <= '0;
      wrong_count_q <= '0;
      hash_count_q  <= 1'b0;
      incorrect_q   <= 1'b0;
      blocked_q     <= 1'b0;
      complete_q    <= 1'b0;
      alarm_q       <= 1'b0;
      temp_q        <= 1'b0;
      gas_q         <= 1'b0;
      tick_count_q  <= '0;
    end else if (step_i) begin
      key_count_q   <= key_count_d;
      wrong_count_q <= wrong_count_d;
      hash_count_q  <= hash_count_d;
      incorrect_q   <= incorrect_d;
      blocked_q     <= blocked_d;
      complete_q    <= complete_d;
      alarm_q       <= alarm_d;
      temp_q        <= temp_d;
      gas_q         <= gas_d;
      tick_count_q  <= tick_count_d;
    end
  end

  // Key store, no reset: every entry is written before the compare reads it.
  always_ff @(posedge clk_i) begin
    if (step_i && key_store) begin
      keys_q[key_count_q] <= item_i.key_code;
    end
  end

  assign result_o.alarm_active   = alarm_d;
  assign result_o.incorrect_code = incorrect_d;
  assign result_o.system_blocked = blocked_d;
  assign result_o.code_complete  = complete_d;
  assign result_o.temp_alarm     = temp_d;
  assign result_o.gas_alarm      = gas_d;
  assign result_o.code_accepted  = accepted;

`ifndef SYNTH
  a_blocked_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blocked_q |=> blocked_q)
    else $error("lockout released without reset");

  a_incorrect_needs_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    incorrect_q |-> complete_q)
    else $error("wrong-code flag set without a complete code");

  a_accept_clears_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && accepted) |=> (!alarm_q && complete_q && !incorrect_q))
    else $error("matching code did not disarm");

  a_wrong_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> (wrong_count_q >= $past(wrong_count_q)))
    else $error("failure count went down");
`endif

endmodule

`default_nettype wire

/* rtl/alarm_keypad_code_lock.sv */
// Top level of the alarm keypad code lock: channel registers around the core.
`default_nettype none

// Alarm panel with four-key code disarm and wrong-code lockout. Each request on
// item_if is either a key release (func 0) or a sensor tick (func 1); every
// request yields exactly one result request on result_if carrying all status
// flags after the update. Throughput is one request per clock while result_if
// is not stalled: a request is held in the input register, and the state
// update and result are computed by a single shallow pass (one 16-bit compare,
// one 12-bit signed compare, a 32-bit code compare) and land in the result
// register. A stalled result_if holds the input register. The result register
// decouples the sides: a new request is taken while a finished result waits.
// Configuration writes (cfg_if, always ready) take effect at the next edge and
// must only be issued while no request is in flight.
module alarm_keypad_code_lock (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  akcl_item_if.sink      item_if,
  akcl_result_if.source  result_if,
  akcl_cfg_if.sink       cfg_if
);

  akcl_pkg::cfg_t    cfg;
  akcl_pkg::result_t result_d;
  akcl_pkg::item_t   item_q;
  akcl_pkg::result_t result_q;
  logic              item_valid_q, item_valid_d;
  logic              result_valid_q, result_valid_d;
  logic              step;

  // Process the buffered request whenever the result register can take it.
  assign step          = item_valid_q && (!result_valid_q || result_if.ready);
  assign item_if.ready = !item_valid_q || step;

  always_comb begin
    item_valid_d = item_valid_q;
    if (item_if.valid && item_if.ready) begin
      item_valid_d = 1'b1;
    end else if (step) begin
      item_valid_d = 1'b0;
    end
  end

  always_comb begin
    result_valid_d = result_valid_q;
    if (step) begin
      result_valid_d = 1'b1;
    end else if (result_if.ready) begin
      result_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q   <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      item_valid_q   <= item_valid_d;
      result_valid_q <= result_valid_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (item_if.valid && item_if.ready) begin
      item_q <= item_if.data;
    end
    if (step) begin
      result_q <= result_d;
    end
  end

  akcl_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_if),
    .cfg_o  (cfg)
  );

  akcl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result_d)
  );

  assign result_if.valid = result_valid_q;
  assign result_if.data  = result_q;

`ifndef SYNTH
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_q && !result_if.ready) |=> (result_valid_q && $stable(result_q)))
    else $error("pending result dropped or changed");

  a_step_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> item_valid_q)
    else $error("processing without a buffered request");

  a_step_fills_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> result_valid_q)
    else $error("processed request produced no result");
`endif

endmodule

`default_nettype wire
